FILE: rtl/indexed_vector_store_core_assert.svh
// Assertion macros shared by the indexed vector store checkers.
// Depends on a clk and an active-low rst_n in the including scope.
`ifndef INDEXED_VECTOR_STORE_CORE_ASSERT_SVH
`define INDEXED_VECTOR_STORE_CORE_ASSERT_SVH

// checked only outside reset
`define IVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define IVS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ivs_pkg.sv
// Package for the indexed vector store: sizes, operation and status codes,
// request/result structs and the per-cell command struct. No dependencies.
`timescale 1ns / 1ps
package ivs_pkg;

  localparam int CAPACITY   = 64;
  localparam int WORD_WIDTH = 64;

  localparam int OP_W   = 3;
  localparam int POS_W  = 7;
  localparam int FLD_W  = 64;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int IDX_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_GET    = 3'd2,
    OP_SET    = 3'd3,
    OP_INSERT = 3'd4,
    OP_REMOVE = 3'd5,
    OP_CLEAR  = 3'd6
  } ivs_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } ivs_status_t;

  typedef struct packed {
    ivs_op_t            operation;
    logic [POS_W-1:0]   position;
    logic [FLD_W-1:0]   word_in;
  } ivs_req_t;

  typedef struct packed {
    ivs_status_t        status;
    logic [FLD_W-1:0]   word_out;
    logic [POS_W-1:0]   count_now;
  } ivs_rsp_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  shift_up;
    logic                  shift_down;
    logic [IDX_W-1:0]      pos;
    logic [IDX_W-1:0]      rd_idx;
    logic [WORD_WIDTH-1:0] wdata;
  } ivs_cell_cmd_t;

endpackage

FILE: rtl/indexed_vector_store_core.sv
// Indexed vector store top level: request decode, live count, row of cells
// and result register. Uses ivs_pkg and ivs_cell.
//
// One request per clock unless stalled: every operation, insert and remove
// included, finishes in one step because all CAPACITY cells shift together and
// the read word is a one-hot OR across the row. The result sits in one
// output register; a new request is taken whenever that register is empty
// or is being taken in the same cycle, so in_stall follows out_stall.
`timescale 1ns / 1ps
module indexed_vector_store_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ivs_pkg::ivs_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output ivs_pkg::ivs_rsp_t out_req
);
  import ivs_pkg::*;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ivs_rsp_t              out_r, out_nxt;
  logic                  accept;
  ivs_cell_cmd_t         cmd;
  ivs_status_t           status;
  logic                  rd_en;
  logic [IDX_W-1:0]      cnt_x, pos_x, cap_x;
  logic [WORD_WIDTH-1:0] rd_word;

  logic [WORD_WIDTH-1:0] cell_word [CAPACITY];
  logic [WORD_WIDTH-1:0] cell_rd   [CAPACITY];

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign cnt_x = IDX_W'(count_r);
  assign pos_x = IDX_W'(in_req.position);
  assign cap_x = IDX_W'(CAPACITY);

  always_comb begin
    cmd        = '0;
    cmd.wdata  = in_req.word_in[WORD_WIDTH-1:0];
    status     = ST_OK;
    rd_en      = 1'b0;
    count_nxt  = count_r;
    unique case (in_req.operation)
      OP_PUSH: begin
        if (cnt_x >= cap_x) begin
          status = ST_FULL;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.pos   = cnt_x;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_POP: begin
        if (count_r == '0) begin
          status = ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          cmd.rd_idx = cnt_x - IDX_W'(1);
          count_nxt  = count_r - CNT_W'(1);
        end
      end
      OP_GET: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          rd_en      = 1'b1;
          cmd.rd_idx = pos_x;
        end
      end
      OP_SET: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          rd_en      = 1'b1;
          cmd.rd_idx = pos_x;
          cmd.wr_en  = 1'b1;
          cmd.pos    = pos_x;
        end
      end
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status = ST_RANGE;
        end else if (cnt_x >= cap_x) begin
          status = ST_FULL;
        end else begin
          cmd.wr_en    = 1'b1;
          cmd.shift_up = 1'b1;
          cmd.pos      = pos_x;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status = ST_RANGE;
        end else begin
          rd_en          = 1'b1;
          cmd.rd_idx     = pos_x;
          cmd.shift_down = 1'b1;
          cmd.pos        = pos_x;
          count_nxt      = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    if (!accept) begin
      cmd.wr_en      = 1'b0;
      cmd.shift_up   = 1'b0;
      cmd.shift_down = 1'b0;
      count_nxt      = count_r;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_WIDTH-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = cell_word[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = cell_word[i+1];
    end
    ivs_cell u_cell (
      .clk       (clk),
      .cell_idx  (IDX_W'(i)),
      .cmd       (cmd),
      .prev_word (prev_w),
      .next_word (next_w),
      .word_o    (cell_word[i]),
      .rd_word   (cell_rd[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt     = 1'b1;
      out_nxt.status    = status;
      out_nxt.word_out  = rd_en ? FLD_W'(rd_word) : '0;
      out_nxt.count_now = POS_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_r;

endmodule

FILE: rtl/ivs_cell.sv
// One storage cell of the indexed vector store: holds one word, loads a
// neighbor's word on shifts or the request word on writes. Uses ivs_pkg.
`timescale 1ns / 1ps
module ivs_cell (
  input  logic                          clk,
  input  logic [ivs_pkg::IDX_W-1:0]     cell_idx,
  input  ivs_pkg::ivs_cell_cmd_t        cmd,
  input  logic [ivs_pkg::WORD_WIDTH-1:0] prev_word,
  input  logic [ivs_pkg::WORD_WIDTH-1:0] next_word,
  output logic [ivs_pkg::WORD_WIDTH-1:0] word_o,
  output logic [ivs_pkg::WORD_WIDTH-1:0] rd_word
);
  import ivs_pkg::*;

  logic [WORD_WIDTH-1:0] word_r;
  logic [WORD_WIDTH-1:0] word_nxt;

  always_comb begin
    word_nxt = word_r;
    if (cmd.wr_en && (cell_idx == cmd.pos)) begin
      word_nxt = cmd.wdata;
    end else if (cmd.shift_up && (cell_idx > cmd.pos)) begin
      word_nxt = prev_word;
    end else if (cmd.shift_down && (cell_idx >= cmd.pos)) begin
      word_nxt = next_word;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word_o  = word_r;
  assign rd_word = (cell_idx == cmd.rd_idx) ? word_r : '0;

endmodule

FILE: rtl/ivs_checker.sv
// Port-level checks for indexed_vector_store_core, bound to the top level.
// Uses ivs_pkg and the macros of indexed_vector_store_core_assert.svh.
`timescale 1ns / 1ps
`include "indexed_vector_store_core_assert.svh"
module ivs_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input ivs_pkg::ivs_req_t in_req,
  input logic              out_valid,
  input logic              out_stall,
  input ivs_pkg::ivs_rsp_t out_req
);
  import ivs_pkg::*;

  `IVS_ASSERT_ALWAYS(a_rst_clears, !rst_n |=> !out_valid, "result valid after reset")
  `IVS_ASSERT(a_hold, out_valid && out_stall |=> out_valid && $stable(out_req), "stalled result changed")
  `IVS_ASSERT(a_free_accepts, !out_valid |-> !in_stall, "request stalled with empty result register")
  `IVS_ASSERT(a_err_zero, out_valid && out_req.status != ST_OK |-> out_req.word_out == '0, "nonzero word on error")
  `IVS_ASSERT(a_clear, in_valid && !in_stall && in_req.operation == OP_CLEAR |=> out_valid && out_req.count_now == '0 && out_req.status == ST_OK, "clear result wrong")

endmodule

bind indexed_vector_store_core ivs_checker u_ivs_checker (.*);
